@@ rtl/core/slm_pkg.sv @@
// Shared types, constants and the log2 table function of the sound level meter.
package slm_pkg;

	// Default build widths
	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int LOG_TABLE_BITS_DEF = 6;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASURE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd2;

	// Register values after reset
	localparam logic [15:0]        SMOOTHING_RST = 16'd66;
	localparam logic [15:0]        MEASURE_RST   = 16'd5000;
	localparam logic signed [15:0] OFFSET_RST    = -16'sd6656;

	// Filter arithmetic
	localparam int ALPHA_ONE  = 65536;
	localparam int ROUND_HALF = 32768;

	// log2 and dB conversion
	localparam int                 FRAC_BITS     = 31;
	localparam logic [16:0]        LOG_ONE       = 17'h10000;
	localparam logic signed [19:0] DB_PER_OCTAVE = 20'sd394566;
	localparam int                 ROUND_DB      = 8388608;
	localparam int                 DB_MAX        = 32767;
	localparam int                 DB_MIN        = -32768;

	typedef struct packed {
		logic [15:0]        smoothing_factor;
		logic [15:0]        measure_length;
		logic signed [15:0] db_offset;
	} slm_cfg_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL_LO,
		B_MUL_HI,
		B_MUL_X,
		B_UPDATE,
		B_CHECK,
		B_NORM,
		B_TABLE,
		B_INTERP,
		B_SCALE,
		B_OFFSET,
		B_ZERO
	} back_state_t;

	// log2(1 + i/2^tb) in Q16 by truncating square-and-compare; top entry is exactly one
	function automatic logic [16:0] log2_entry(input int unsigned i, input int unsigned tb);
		logic [63:0] m;
		logic [16:0] r;
		r = '0;
		m = 64'd65536 + ((64'(i) << 16) >> tb);
		for (int b = 15; b >= 0; b--) begin
			m = (m * m) >> 16;
			if (m >= 64'd131072) begin
				m = m >> 1;
				r[b] = 1'b1;
			end
		end
		if (i == (32'd1 << tb)) begin
			r = LOG_ONE;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/sound_level_meter.sv @@
// A sample that closes a measurement passes the filter update, the level check, the binary
// normalisation steps, table lookup, interpolation, dB scaling and the offset before its result
// is loaded; a zero level goes from the check straight to the result. The shared multiplier
// takes three products per filter update, and the back end finishes one sample before it takes
// the next, while the queue lets the front end take further samples; a result waits for a free output.
// Reset clears the level, sample count, queue and result valid; registers take defaults.
module sound_level_meter #(
	parameter int SAMPLE_BITS    = slm_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = slm_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [SAMPLE_BITS-1:0]          sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [15:0]              level_db,
	output logic                            level_zero,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [slm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import slm_pkg::*;

	slm_cfg_t             cfg_q;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_push;
	logic                 q_pop;
	logic [SAMPLE_BITS:0] q_wdata;
	logic [SAMPLE_BITS:0] q_rdata;

	// Accept a configuration transfer in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_factor <= SMOOTHING_RST;
			cfg_q.measure_length   <= MEASURE_RST;
			cfg_q.db_offset        <= OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SMOOTHING: cfg_q.smoothing_factor <= cfg_data;
				CFG_MEASURE:   cfg_q.measure_length   <= cfg_data;
				CFG_OFFSET:    cfg_q.db_offset        <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	slm_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample  (sample),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	slm_queue #(
		.WIDTH(SAMPLE_BITS + 1),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.full     (q_full),
		.empty    (q_empty)
	);

	slm_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level_db  (level_db),
		.level_zero(level_zero)
	);

endmodule

@@ rtl/core/slm_front.sv @@
// Front end of the sound level meter: sample acceptance and measurement counting.
module slm_front #(
	parameter int SAMPLE_BITS = slm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  slm_pkg::slm_cfg_t      cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   q_full,
	output logic                   q_push,
	output logic [SAMPLE_BITS:0]   q_data
);
	import slm_pkg::*;

	logic [15:0] count_q;
	logic [15:0] count_next;
	logic        closes;

	// Take a sample whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// Tag the sample that closes a measurement
	assign count_next = count_q + 16'd1;
	assign closes     = (count_next == cfg.measure_length);
	assign q_data     = {closes, sample};

	// Advance the sample count on every transfer, restart after a closing sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= closes ? 16'd0 : count_next;
		end
	end

endmodule

@@ rtl/core/slm_queue.sv @@
// Short first-in first-out queue between the front and back ends.
module slm_queue #(
	parameter int WIDTH = slm_pkg::SAMPLE_BITS_DEF + 1,
	parameter int DEPTH = slm_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	import slm_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      count_q;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_q];

	// Store the entry at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("queue fill count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");
`endif

endmodule

@@ rtl/core/slm_back.sv @@
// Back end of the sound level meter: filter update, log conversion and result register.
module slm_back #(
	parameter int SAMPLE_BITS    = slm_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = slm_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slm_pkg::slm_cfg_t    cfg,
	input  logic                 q_empty,
	input  logic [SAMPLE_BITS:0] q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   level_db,
	output logic                 level_zero
);
	import slm_pkg::*;

	localparam int LB     = SAMPLE_BITS + 16;
	localparam int LO     = LB / 2;
	localparam int HI     = LB - LO;
	localparam int MA     = (SAMPLE_BITS > HI) ? SAMPLE_BITS : HI;
	localparam int PW     = MA + 17;
	localparam int ACCW   = LB + 17;
	localparam int NSTEPS = $clog2(LB);
	localparam int STW    = $clog2(NSTEPS);
	localparam int SEG    = FRAC_BITS - LOG_TABLE_BITS;
	localparam int TABSZ  = (1 << LOG_TABLE_BITS) + 1;
	localparam int TIW    = LOG_TABLE_BITS + 1;
	localparam int IPW    = 17 + SEG;
	localparam int L2W    = NSTEPS + 18;
	localparam int VW     = L2W + 20;
	localparam int DBW    = L2W - 4;

	back_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] x_q;
	logic                   emit_q;
	logic [LB-1:0]          y_q;
	logic [ACCW-1:0]        acc_q;
	logic [PW-1:0]          prod_q;
	logic [LB-1:0]          norm_q;
	logic [NSTEPS-1:0]      shift_q;
	logic [STW-1:0]         step_q;
	logic [16:0]            t0_q;
	logic [16:0]            diff_q;
	logic [SEG-1:0]         rem_q;
	logic signed [L2W-1:0]  l2_q;
	logic signed [DBW-1:0]  db_q;
	logic                   out_valid_q;
	logic signed [15:0]     level_db_q;
	logic                   level_zero_q;

	logic                   out_free;
	logic                   out_load;
	logic [16:0]            bcoef;
	logic [MA-1:0]          mul_a;
	logic [16:0]            mul_b;
	logic [PW-1:0]          mul_p;
	logic [ACCW-1:0]        acc_sum;
	logic [NSTEPS-1:0]      sh_amt;
	logic [LB-1:0]          hi_mask;
	logic [LB+29:0]         frac_ext;
	logic [FRAC_BITS-1:0]   frac;
	logic [LOG_TABLE_BITS-1:0] idx;
	logic [SEG-1:0]         rem;
	logic [16:0]            tab_lo;
	logic [16:0]            tab_hi;
	logic [IPW-1:0]         ip;
	logic [16:0]            lf;
	logic [NSTEPS-1:0]      pos;
	logic signed [L2W-1:0]  pm16;
	logic signed [L2W-1:0]  l2_d;
	logic signed [VW-1:0]   v;
	logic signed [DBW-1:0]  db_d;
	logic signed [DBW:0]    sum;
	logic signed [15:0]     db_sat;
	logic [16:0]            log_tab [TABSZ];

	// Constant log2 table
	for (genvar gi = 0; gi < TABSZ; gi++) begin : g_tab
		assign log_tab[gi] = log2_entry(gi, LOG_TABLE_BITS);
	end

	assign out_free = !out_valid_q || out_ready;

	// Shared multiplier: two halves of the level, then the sample
	assign bcoef = 17'(ALPHA_ONE) - {1'b0, cfg.smoothing_factor};
	always_comb begin
		mul_a = MA'(y_q[LO-1:0]);
		mul_b = bcoef;
		if (state_q == B_MUL_HI) begin
			mul_a = MA'(y_q[LB-1:LO]);
		end else if (state_q == B_MUL_X) begin
			mul_a = MA'(x_q);
			mul_b = {1'b0, cfg.smoothing_factor};
		end
	end
	assign mul_p   = PW'(mul_a) * PW'(mul_b);
	assign acc_sum = acc_q + (ACCW'(prod_q) << 16);

	// Normalise one binary step at a time
	assign sh_amt  = {1'b1, {(NSTEPS-1){1'b0}}} >> step_q;
	assign hi_mask = ~({LB{1'b1}} >> sh_amt);

	// Table lookup from the bits below the leading one
	assign frac_ext = {norm_q[LB-2:0], 31'b0};
	assign frac     = frac_ext[LB+29 -: FRAC_BITS];
	assign idx      = frac[FRAC_BITS-1 -: LOG_TABLE_BITS];
	assign rem      = frac[SEG-1:0];
	assign tab_lo   = log_tab[{1'b0, idx}];
	assign tab_hi   = log_tab[TIW'(idx) + TIW'(1)];

	// Interpolate and add the octave
	assign ip   = IPW'(diff_q) * IPW'(rem_q);
	assign lf   = t0_q + 17'(ip >> SEG);
	assign pos  = NSTEPS'(LB - 1) - shift_q;
	assign pm16 = L2W'($signed({1'b0, pos})) - L2W'(16);
	assign l2_d = (pm16 <<< 16) + $signed(L2W'(lf));

	// Scale to dB with round half up
	assign v    = VW'(l2_q) * VW'(DB_PER_OCTAVE) + VW'(ROUND_DB);
	assign db_d = $signed(v[VW-1:24]);

	// Apply the calibration offset and saturate
	assign sum = (DBW+1)'(db_q) + (DBW+1)'(cfg.db_offset);
	always_comb begin
		priority if (sum > (DBW+1)'(DB_MAX)) begin
			db_sat = 16'(DB_MAX);
		end else if (sum < (DBW+1)'(DB_MIN)) begin
			db_sat = 16'(DB_MIN);
		end else begin
			db_sat = 16'(sum);
		end
	end

	// Sequencer: next state, queue pop and result load
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = B_MUL_LO;
				end
			end
			B_MUL_LO: state_d = B_MUL_HI;
			B_MUL_HI: state_d = B_MUL_X;
			B_MUL_X:  state_d = B_UPDATE;
			B_UPDATE: state_d = emit_q ? B_CHECK : B_IDLE;
			B_CHECK:  state_d = (y_q == '0) ? B_ZERO : B_NORM;
			B_NORM: begin
				if (step_q == STW'(NSTEPS - 1)) begin
					state_d = B_TABLE;
				end
			end
			B_TABLE:  state_d = B_INTERP;
			B_INTERP: state_d = B_SCALE;
			B_SCALE:  state_d = B_OFFSET;
			B_OFFSET, B_ZERO: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the running level; write it back after the last product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q <= '0;
		end else if (state_q == B_UPDATE) begin
			y_q <= acc_sum[LB+15:16];
		end
	end

	// Working registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (q_pop) begin
					x_q    <= q_data[SAMPLE_BITS-1:0];
					emit_q <= q_data[SAMPLE_BITS];
				end
			end
			B_MUL_LO: begin
				prod_q <= mul_p;
				acc_q  <= ACCW'(ROUND_HALF);
			end
			B_MUL_HI: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + ACCW'(prod_q);
			end
			B_MUL_X: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + (ACCW'(prod_q) << LO);
			end
			B_CHECK: begin
				norm_q  <= y_q;
				shift_q <= '0;
				step_q  <= '0;
			end
			B_NORM: begin
				if ((norm_q & hi_mask) == '0) begin
					norm_q  <= norm_q << sh_amt;
					shift_q <= shift_q | sh_amt;
				end
				step_q <= step_q + STW'(1);
			end
			B_TABLE: begin
				t0_q   <= tab_lo;
				diff_q <= tab_hi - tab_lo;
				rem_q  <= rem;
			end
			B_INTERP: l2_q <= l2_d;
			B_SCALE:  db_q <= db_d;
			default: ;
		endcase
	end

	// Result register: free up on transfer, load when a level is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			level_db_q   <= (state_q == B_ZERO) ? 16'(DB_MIN) : db_sat;
			level_zero_q <= (state_q == B_ZERO);
		end
	end

	assign out_valid  = out_valid_q;
	assign level_db   = level_db_q;
	assign level_zero = level_zero_q;

`ifndef SYNTHESIS
	a_zero_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && level_zero_q) |-> (level_db_q == 16'(DB_MIN)))
		else $error("zero level result not saturated");
	a_check_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CHECK) |-> emit_q)
		else $error("log conversion started on a sample that closes no measurement");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=>
		(out_valid_q && $stable(level_db_q) && $stable(level_zero_q)))
		else $error("waiting result changed before its transfer");
`endif

endmodule

@@ tb/sound_level_meter_test.sv @@
// Self-checking testbench of the sound level meter: predicted dB readings against the block.
module sound_level_meter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slm_pkg::*;

	localparam int          LEVEL_W        = SAMPLE_BITS_DEF + 16;
	localparam int          TBL_BITS       = LOG_TABLE_BITS_DEF;
	localparam int          TBL_SIZE       = 1 << TBL_BITS;
	localparam int          SEG_W          = FRAC_BITS - TBL_BITS;
	localparam longint      DB_PER_OCT_Q16 = 394566;
	// Settling margin before a register write, above what the back end needs for a closing sample
	localparam int          SETTLE_CYCLES  = 32;
	localparam int          LONG_HOLD      = 300;
	localparam int          PHASES         = 14;
	localparam int          PHASE_ITEMS    = 100;
	// Watchdog bound, set for the slowest run with every item closing under the longest gaps
	localparam int unsigned CYCLE_LIMIT    = 500000;

	typedef struct packed {
		logic [SAMPLE_BITS_DEF-1:0] value;
		logic [3:0]                 gap;
	} slm_feed_t;

	typedef struct packed {
		logic signed [15:0] db;
		logic               zero;
	} reading_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic [SAMPLE_BITS_DEF-1:0] sample     = '0;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic signed [15:0]         level_db;
	logic                       level_zero;
	logic                       cfg_valid  = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index  = '0;
	logic [CFG_DATA_W-1:0]      cfg_data   = '0;

	// Predicted meter state and register copies
	logic [16:0]        log2_seg [0:TBL_SIZE];
	logic [15:0]        alpha_now;
	logic [15:0]        length_now;
	logic signed [15:0] offset_now;
	logic [LEVEL_W-1:0] level_now;
	logic [15:0]        count_now;

	slm_feed_t   feed_q[$];
	reading_t    readings_due[$];
	int          errors       = 0;
	bit          tx_gaps      = 1'b0;
	bit          rx_gaps      = 1'b0;
	int          hold_asks    = 0;
	int          holds_served = 0;
	int          ready_wait   = 0;
	int unsigned cycles_run   = 0;

	sound_level_meter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.level_db   (level_db),
		.level_zero (level_zero),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial forever #6 clk = ~clk;

	// log2 of the segment start 1 + seg/2^TBL_BITS in Q16
	function automatic logic [16:0] seg_log2(input int unsigned seg);
		logic [63:0] m;
		logic [16:0] bits;
		bits = '0;
		m = 64'd65536 + ((64'(seg) << 16) >> TBL_BITS);
		// square the mantissa; each pass beyond two gives one result bit
		for (int w = 15; w >= 0; w--) begin
			m = (m * m) >> 16;
			bits[w] = (m >= 64'd131072);
			if (bits[w]) begin
				m = m >> 1;
			end
		end
		return bits;
	endfunction

	// Nonzero level to Q8.8 dB with the calibration offset, saturated
	function automatic logic signed [15:0] db_of_level(input logic [LEVEL_W-1:0] y);
		int                   msb;
		logic [63:0]          wide;
		logic [FRAC_BITS-1:0] frac;
		logic [SEG_W-1:0]     rem;
		int unsigned          idx;
		longint unsigned      t0, t1, lf;
		longint               l2, db;
		msb = 0;
		for (int k = 0; k < LEVEL_W; k++) begin
			if (y[k]) begin
				msb = k;
			end
		end
		// align the bits below the leading one
		wide = 64'(y);
		if (msb >= FRAC_BITS) begin
			wide = wide >> (msb - FRAC_BITS);
		end else begin
			wide = wide << (FRAC_BITS - msb);
		end
		frac = wide[FRAC_BITS-1:0];
		idx = 32'(frac[FRAC_BITS-1:SEG_W]);
		rem = frac[SEG_W-1:0];
		// interpolate within the segment, truncating
		t0 = 64'(log2_seg[idx]);
		t1 = 64'(log2_seg[idx+1]);
		lf = t0 + (((t1 - t0) * 64'(rem)) >> SEG_W);
		l2 = longint'(msb - 16) * longint'(65536) + longint'(lf);
		db = (l2 * DB_PER_OCT_Q16 + longint'(ROUND_DB)) >>> 24;
		db = db + longint'(offset_now);
		if (db > longint'(DB_MAX)) begin
			db = longint'(DB_MAX);
		end
		if (db < longint'(DB_MIN)) begin
			db = longint'(DB_MIN);
		end
		return 16'(db);
	endfunction

	// Advance the filter by one sample and queue a reading when a measurement closes
	function automatic void meter_step(input logic [SAMPLE_BITS_DEF-1:0] x);
		logic [63:0] acc;
		reading_t    r;
		acc = 64'(level_now) * (64'(ALPHA_ONE) - 64'(alpha_now))
			+ ((64'(x) << 16) * 64'(alpha_now)) + 64'(ROUND_HALF);
		level_now = acc[LEVEL_W+15:16];
		count_now = count_now + 16'd1;
		if (count_now == length_now) begin
			count_now = '0;
			if (level_now == '0) begin
				r.db = 16'(DB_MIN);
				r.zero = 1'b1;
			end else begin
				r.db = db_of_level(level_now);
				r.zero = 1'b0;
			end
			readings_due.push_back(r);
		end
	endfunction

	function automatic logic [SAMPLE_BITS_DEF-1:0] draw_sample();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return SAMPLE_BITS_DEF'($urandom);
		end else if (pick < 70) begin
			return SAMPLE_BITS_DEF'($urandom_range(0, 255));
		end else if (pick < 85) begin
			return '0;
		end
		return SAMPLE_BITS_DEF'($urandom_range(24'hF00000, 24'hFFFFFF));
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on %s at %0t: got %0d, want %0d", what, $time, got, want);
		errors++;
	endtask

	task automatic post_value(input logic [SAMPLE_BITS_DEF-1:0] v);
		slm_feed_t item;
		item.value = v;
		item.gap = tx_gaps ? 4'($urandom_range(0, 15)) : 4'd0;
		feed_q.push_back(item);
	endtask

	task automatic post_samples(input int n);
		for (int i = 0; i < n; i++) begin
			post_value(draw_sample());
		end
	endtask

	// Single register write through the configuration channel
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SMOOTHING: alpha_now = value;
			CFG_MEASURE:   length_now = value;
			CFG_OFFSET:    offset_now = value;
			default: ;
		endcase
	endtask

	// Wait until every sample is in and every reading is out, then let the block settle
	task automatic settle();
		do @(posedge clk);
		while (feed_q.size() != 0 || in_valid || readings_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Feed the samples left in the current measurement so the count is back at zero
	task automatic close_measurement();
		if (count_now != '0) begin
			post_samples(int'(16'(length_now - count_now)));
			settle();
		end
	endtask

	// Sample driver: per-sample gap, then offer until the transfer
	always @(posedge clk or negedge arst_n) begin : feed_driver
		slm_feed_t head;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
		end else begin
			if (in_valid && in_ready) begin
				meter_step(sample);
			end
			if (!in_valid || in_ready) begin
				if (feed_q.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					head = feed_q[0];
					if (head.gap != '0) begin
						head.gap = head.gap - 4'd1;
						feed_q[0] = head;
						in_valid <= 1'b0;
					end else begin
						void'(feed_q.pop_front());
						sample <= head.value;
						in_valid <= 1'b1;
					end
				end
			end
		end
	end

	// Reading monitor and receiver pacing
	always @(posedge clk or negedge arst_n) begin : reading_monitor
		reading_t due;
		int       pause;
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_wait <= 0;
			holds_served <= 0;
		end else begin
			pause = 0;
			// compare each result transfer with the oldest reading due
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					note_mismatch("reading with none due", longint'(level_db), longint'(0));
				end else begin
					due = readings_due.pop_front();
					if (level_db !== due.db) begin
						note_mismatch("level_db", longint'(level_db), longint'(due.db));
					end
					if (level_zero !== due.zero) begin
						note_mismatch("level_zero", longint'(level_zero), longint'(due.zero));
					end
				end
				pause = rx_gaps ? int'($urandom_range(0, 15)) : 0;
			end
			// drop ready for a long hold, a drawn pause, or keep it up
			if (holds_served != hold_asks) begin
				holds_served <= hold_asks;
				ready_wait <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				ready_wait <= pause;
				out_ready <= (pause == 0);
			end else if (ready_wait != 0) begin
				ready_wait <= ready_wait - 1;
				out_ready <= (ready_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles_run <= cycles_run + 1;
		if (cycles_run == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		alpha_now = SMOOTHING_RST;
		length_now = MEASURE_RST;
		offset_now = OFFSET_RST;
		level_now = '0;
		count_now = '0;
		for (int i = 0; i < TBL_SIZE; i++) begin
			log2_seg[i] = seg_log2(i);
		end
		log2_seg[TBL_SIZE] = LOG_ONE;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Zero level, full scale saturating high, decay back to zero
		write_reg(CFG_MEASURE, 16'd1);
		write_reg(CFG_SMOOTHING, 16'hFFFF);
		write_reg(CFG_OFFSET, 16'h0000);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		post_value(24'h000000);
		post_value(24'hFFFFFF);
		post_value(24'h800000);
		post_value(24'h7FFFFF);
		post_value(24'h000001);
		post_value(24'h000000);
		post_value(24'h000000);
		post_value(24'h000001);
		settle();

		// Smallest weight with the most negative offset saturates low
		write_reg(CFG_SMOOTHING, 16'd1);
		write_reg(CFG_OFFSET, 16'h8000);
		post_value(24'h000001);
		post_value(24'h000002);
		settle();

		// Zero weight freezes the level; largest offset
		write_reg(CFG_SMOOTHING, 16'd0);
		write_reg(CFG_OFFSET, 16'h7FFF);
		post_value(24'hFFFFFF);
		post_value(24'h000000);
		settle();

		// Half weight, default offset, three samples per reading
		write_reg(CFG_SMOOTHING, 16'h8000);
		write_reg(CFG_OFFSET, OFFSET_RST);
		write_reg(CFG_MEASURE, 16'd3);
		post_value(24'h123456);
		post_value(24'hFEDCBA);
		post_value(24'h00FF00);
		post_value(24'h555555);
		post_value(24'hAAAAAA);
		post_value(24'h0F0F0F);
		settle();

		// Receiver holds off while the sender keeps offering: the block backs up
		write_reg(CFG_MEASURE, 16'd1);
		write_reg(CFG_SMOOTHING, 16'($urandom_range(1, 65535)));
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_asks <= hold_asks + 1;
		post_samples(40);
		settle();

		// Longest measurement, then a length just past the count closes it early
		write_reg(CFG_SMOOTHING, SMOOTHING_RST);
		write_reg(CFG_MEASURE, 16'hFFFF);
		post_samples(PHASE_ITEMS);
		settle();
		write_reg(CFG_MEASURE, count_now + 16'd7);
		close_measurement();

		// Random register settings, each phase closed on a measurement boundary
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: write_reg(CFG_SMOOTHING, 16'd1);
				1: write_reg(CFG_SMOOTHING, 16'hFFFF);
				2: write_reg(CFG_SMOOTHING, 16'($urandom_range(1, 1023)));
				3: write_reg(CFG_SMOOTHING, 16'($urandom_range(1024, 65535)));
				4: write_reg(CFG_SMOOTHING, SMOOTHING_RST);
				default: write_reg(CFG_SMOOTHING, 16'd0);
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(CFG_MEASURE, 16'd1);
				1: write_reg(CFG_MEASURE, 16'd2);
				2: write_reg(CFG_MEASURE, 16'($urandom_range(3, 8)));
				default: write_reg(CFG_MEASURE, 16'($urandom_range(9, 40)));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(CFG_OFFSET, 16'h8000);
				1: write_reg(CFG_OFFSET, 16'h7FFF);
				2: write_reg(CFG_OFFSET, OFFSET_RST);
				default: write_reg(CFG_OFFSET, 16'($urandom));
			endcase
			tx_gaps = (ph % 3) != 2;
			rx_gaps = (ph % 4) != 3;
			post_samples(PHASE_ITEMS);
			settle();
			close_measurement();
		end

		settle();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
